/* hdl/acp_pkg.sv */
package acp_pkg;

   localparam logic [16:0] POS_MAX         = 17'h1FFFF;
   localparam logic [3:0]  SM_NIBBLE_RESET = 4'd12;
   localparam logic [7:0]  CLA_NIBBLE_MASK = 8'h0F;
   localparam logic [16:0] SHORT_LE_MAX    = 17'd256;
   localparam logic [16:0] EXT_LE_MAX      = 17'd65536;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic        has_data;
      logic        has_summary;
      logic [7:0]  body_byte;
      logic [16:0] byte_count;
      logic [7:0]  cla;
      logic [7:0]  ins;
      logic [7:0]  p1;
      logic [7:0]  p2;
      logic [15:0] lc;
      logic [16:0] le;
      logic        extended;
      logic        secure_messaging;
   } acp_entry_type;

   typedef struct packed {
      logic          valid;
      acp_entry_type entry;
   } acp_slot_type;

endpackage

/* hdl/apdu_interfaces.sv */
interface apdu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_last;

   modport source (output valid, output in_byte, output is_last, input ready);
   modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface apdu_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  body_byte;
   logic [7:0]  cla;
   logic [7:0]  ins;
   logic [7:0]  p1;
   logic [7:0]  p2;
   logic [15:0] lc;
   logic [16:0] le;
   logic        extended;
   logic        secure_messaging;
   logic [16:0] byte_count;
   logic        last_result;

   modport source (output valid, output kind, output body_byte, output cla, output ins,
                   output p1, output p2, output lc, output le, output extended,
                   output secure_messaging, output byte_count, output last_result,
                   input ready);
   modport sink   (input valid, input kind, input body_byte, input cla, input ins,
                   input p1, input p2, input lc, input le, input extended,
                   input secure_messaging, input byte_count, input last_result,
                   output ready);
endinterface

/* hdl/acp_front.sv */
module acp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [3:0]           csr_write_data,
   apdu_req_if.sink             req_channel,
   input  logic                 queue_full,
   output acp_pkg::acp_slot_type push
);

   logic [3:0]  sm_nibble_ff, sm_nibble_in;
   logic [16:0] position_ff, position_in;
   logic [31:0] header_ff, header_in;
   logic [7:0]  length_byte_ff, length_byte_in;
   logic [15:0] ext_length_ff, ext_length_in;
   logic [15:0] le_capture_ff, le_capture_in;
   logic [1:0]  le_seen_ff, le_seen_in;

   logic        accept;
   logic [7:0]  b;
   logic [16:0] p;
   logic [16:0] n;
   logic [31:0] header_u;
   logic [7:0]  length_u;
   logic [15:0] ext_u;
   logic [15:0] cap_u;
   logic [1:0]  seen_u;
   logic [16:0] short_end;
   logic [16:0] ext_end;
   logic        data;
   logic        ext;
   logic [15:0] lc;
   logic [16:0] le;

   assign req_channel.ready = !queue_full;
   assign accept = req_channel.valid && !queue_full;
   assign b = req_channel.in_byte;
   assign p = position_ff;
   assign n = (p == acp_pkg::POS_MAX) ? p : p + 17'd1;
   assign short_end = 17'd5 + 17'(length_byte_ff);
   assign ext_end = 17'd7 + 17'(ext_length_ff);

   always_comb begin
      header_u = header_ff;
      length_u = length_byte_ff;
      ext_u    = ext_length_ff;
      cap_u    = le_capture_ff;
      seen_u   = le_seen_ff;
      data     = 1'b0;
      if (p != acp_pkg::POS_MAX) begin
         if (p < 17'd4) begin
            header_u = header_ff | (32'(b) << {p[1:0], 3'b000});
         end else if (p == 17'd4) begin
            length_u = b;
         end else begin
            if (p == 17'd5) begin
               ext_u = {b, ext_length_ff[7:0]};
            end else if (p == 17'd6) begin
               ext_u = {ext_length_ff[15:8], b};
            end
            if (length_byte_ff != 8'd0) begin
               if (p < short_end) begin
                  data = 1'b1;
               end else if (p == short_end) begin
                  cap_u  = 16'(b);
                  seen_u = 2'd1;
               end
            end else if (p >= 17'd7 && ext_length_ff != 16'd0) begin
               if (p < ext_end) begin
                  data = 1'b1;
               end else if (p == ext_end) begin
                  cap_u  = {b, 8'h00};
                  seen_u = 2'd1;
               end else if (p == ext_end + 17'd1 && le_seen_ff == 2'd1) begin
                  cap_u  = {le_capture_ff[15:8], b};
                  seen_u = 2'd2;
               end
            end
         end
      end
   end

   always_comb begin
      ext = (n > 17'd5) && (length_u == 8'd0);
      lc  = 16'd0;
      le  = 17'd0;
      if (!ext) begin
         if (n > 17'd5) begin
            lc = 16'(length_u);
            if (seen_u != 2'd0) begin
               le = (cap_u == 16'd0) ? acp_pkg::SHORT_LE_MAX : 17'(cap_u[7:0]);
            end
         end else if (n == 17'd5) begin
            le = (length_u == 8'd0) ? acp_pkg::SHORT_LE_MAX : 17'(length_u);
         end
      end else begin
         if (n <= 17'd7 || ext_u == 16'd0) begin
            if (n >= 17'd7) begin
               le = (ext_u == 16'd0) ? acp_pkg::EXT_LE_MAX : 17'(ext_u);
            end
         end else begin
            lc = ext_u;
            if (seen_u == 2'd2) begin
               le = (cap_u == 16'd0) ? acp_pkg::EXT_LE_MAX : 17'(cap_u);
            end
         end
      end
   end

   always_comb begin
      push.valid                  = accept && (data || req_channel.is_last);
      push.entry.has_data         = data;
      push.entry.has_summary      = req_channel.is_last;
      push.entry.body_byte        = b;
      push.entry.byte_count       = n;
      push.entry.cla              = (n != 17'd0) ? header_u[7:0] : 8'd0;
      push.entry.ins              = header_u[15:8];
      push.entry.p1               = header_u[23:16];
      push.entry.p2               = header_u[31:24];
      push.entry.lc               = lc;
      push.entry.le               = le;
      push.entry.extended         = ext;
      push.entry.secure_messaging = (n != 17'd0) &&
         ((header_u[7:0] & acp_pkg::CLA_NIBBLE_MASK) == {4'h0, sm_nibble_ff});
   end

   always_comb begin
      sm_nibble_in   = csr_write_enable ? csr_write_data : sm_nibble_ff;
      position_in    = position_ff;
      header_in      = header_ff;
      length_byte_in = length_byte_ff;
      ext_length_in  = ext_length_ff;
      le_capture_in  = le_capture_ff;
      le_seen_in     = le_seen_ff;
      if (accept) begin
         if (req_channel.is_last) begin
            position_in    = 17'd0;
            header_in      = 32'd0;
            length_byte_in = 8'd0;
            ext_length_in  = 16'd0;
            le_capture_in  = 16'd0;
            le_seen_in     = 2'd0;
         end else begin
            position_in    = n;
            header_in      = header_u;
            length_byte_in = length_u;
            ext_length_in  = ext_u;
            le_capture_in  = cap_u;
            le_seen_in     = seen_u;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_nibble_ff   <= acp_pkg::SM_NIBBLE_RESET;
         position_ff    <= 17'd0;
         header_ff      <= 32'd0;
         length_byte_ff <= 8'd0;
         ext_length_ff  <= 16'd0;
         le_capture_ff  <= 16'd0;
         le_seen_ff     <= 2'd0;
      end else begin
         sm_nibble_ff   <= sm_nibble_in;
         position_ff    <= position_in;
         header_ff      <= header_in;
         length_byte_ff <= length_byte_in;
         ext_length_ff  <= ext_length_in;
         le_capture_ff  <= le_capture_in;
         le_seen_ff     <= le_seen_in;
      end
   end

endmodule

/* hdl/acp_queue.sv */
module acp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  acp_pkg::acp_slot_type push,
   output logic                  full,
   input  logic                  pop,
   output acp_pkg::acp_slot_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   acp_pkg::acp_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != CNT_W'(0));
   assign head.entry = entries_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

/* hdl/acp_back.sv */
module acp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  acp_pkg::acp_slot_type head,
   output logic                  pop,
   apdu_rsp_if.source            rsp_channel
);

   logic        valid_ff, valid_in;
   logic        phase_ff, phase_in;
   logic        load;
   logic        emit_data;
   logic        kind_ff;
   logic [7:0]  body_byte_ff;
   logic [7:0]  cla_ff;
   logic [7:0]  ins_ff;
   logic [7:0]  p1_ff;
   logic [7:0]  p2_ff;
   logic [15:0] lc_ff;
   logic [16:0] le_ff;
   logic        extended_ff;
   logic        secure_ff;
   logic [16:0] byte_count_ff;
   logic        last_result_ff;

   assign load      = head.valid && (!valid_ff || rsp_channel.ready);
   assign emit_data = head.entry.has_data && !phase_ff;

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      pop      = 1'b0;
      if (valid_ff && rsp_channel.ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         if (emit_data && head.entry.has_summary) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            pop      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_count_ff <= head.entry.byte_count;
         if (emit_data) begin
            kind_ff        <= acp_pkg::KIND_DATA;
            body_byte_ff   <= head.entry.body_byte;
            cla_ff         <= 8'd0;
            ins_ff         <= 8'd0;
            p1_ff          <= 8'd0;
            p2_ff          <= 8'd0;
            lc_ff          <= 16'd0;
            le_ff          <= 17'd0;
            extended_ff    <= 1'b0;
            secure_ff      <= 1'b0;
            last_result_ff <= !head.entry.has_summary;
         end else begin
            kind_ff        <= acp_pkg::KIND_SUMMARY;
            body_byte_ff   <= 8'd0;
            cla_ff         <= head.entry.cla;
            ins_ff         <= head.entry.ins;
            p1_ff          <= head.entry.p1;
            p2_ff          <= head.entry.p2;
            lc_ff          <= head.entry.lc;
            le_ff          <= head.entry.le;
            extended_ff    <= head.entry.extended;
            secure_ff      <= head.entry.secure_messaging;
            last_result_ff <= 1'b1;
         end
      end
   end

   assign rsp_channel.valid            = valid_ff;
   assign rsp_channel.kind             = kind_ff;
   assign rsp_channel.body_byte        = body_byte_ff;
   assign rsp_channel.cla              = cla_ff;
   assign rsp_channel.ins              = ins_ff;
   assign rsp_channel.p1               = p1_ff;
   assign rsp_channel.p2               = p2_ff;
   assign rsp_channel.lc               = lc_ff;
   assign rsp_channel.le               = le_ff;
   assign rsp_channel.extended         = extended_ff;
   assign rsp_channel.secure_messaging = secure_ff;
   assign rsp_channel.byte_count       = byte_count_ff;
   assign rsp_channel.last_result      = last_result_ff;

endmodule

/* hdl/apdu_command_parser.sv */
// Command APDU parser. Takes one APDU byte per req_channel transaction, with
// is_last on the final byte, and answers on rsp_channel with a kind-0
// transaction for each data-field byte and a kind-1 summary (CLA, INS, P1,
// P2, Lc, Le, extended, secure messaging, byte count) after the final byte.
// A byte is taken every cycle while the result queue has room; the result
// side delivers one transaction per cycle while rsp_channel is ready, so a
// final byte that is also a data byte yields two transactions. An accepted
// byte's results are registered in the queue (QUEUE_DEPTH entries), which
// feeds a result register that drives rsp_channel.
// csr_write_data holds the CLA low nibble that flags secure messaging;
// write it only while no APDU is in flight.
module apdu_command_parser #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data,
   apdu_req_if.sink    req_channel,
   apdu_rsp_if.source  rsp_channel
);

   acp_pkg::acp_slot_type push;
   acp_pkg::acp_slot_type head;
   logic                  queue_full;
   logic                  pop;

   acp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_channel      (req_channel),
      .queue_full       (queue_full),
      .push             (push)
   );

   acp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   acp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_channel (rsp_channel)
   );

endmodule

/* bench/tb_apdu_command_parser.sv */
module tb_apdu_command_parser;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 6;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int STUCK_LIMIT     = 5000;

   typedef struct packed {
      logic        kind;
      logic [7:0]  body_byte;
      logic [7:0]  cla;
      logic [7:0]  ins;
      logic [7:0]  p1;
      logic [7:0]  p2;
      logic [15:0] lc;
      logic [16:0] le;
      logic        extended;
      logic        secure_messaging;
      logic [16:0] byte_count;
      logic        last_result;
   } apdu_result_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic [3:0] csr_write_data;

   apdu_req_if req_bus ();
   apdu_rsp_if rsp_bus ();

   apdu_command_parser u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   logic [3:0]  sm_nibble_model = acp_pkg::SM_NIBBLE_RESET;
   logic [16:0] apdu_pos        = '0;
   logic [31:0] apdu_header     = '0;
   logic [7:0]  apdu_len4       = '0;
   logic [15:0] apdu_ext_len    = '0;
   logic [15:0] apdu_le_bytes   = '0;
   logic [1:0]  apdu_le_count   = '0;

   apdu_result_type expected_results[$];
   logic [7:0]      apdu_bytes[$];

   int error_count   = 0;
   int stuck_cycles  = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int stall_left    = 0;
   bit tx_gaps_on    = 1'b0;
   bit rx_stalls_on  = 1'b0;

   task automatic flag_error(input string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   // advance the parse state by one byte and queue the results it causes
   task automatic predict_apdu_byte(input logic [7:0] value, input logic last);
      int              pos;
      int              next_pos;
      int              lc_val;
      int              le_val;
      logic            data_hit;
      logic            ext_form;
      apdu_result_type r;
      pos = int'(apdu_pos);
      next_pos = (apdu_pos < acp_pkg::POS_MAX) ? pos + 1 : pos;
      data_hit = 1'b0;
      if (apdu_pos < acp_pkg::POS_MAX) begin
         if (pos < 4) begin
            apdu_header[8*pos +: 8] = value;
         end else if (pos == 4) begin
            apdu_len4 = value;
         end else begin
            if (pos == 5) begin
               apdu_ext_len[15:8] = value;
            end else if (pos == 6) begin
               apdu_ext_len[7:0] = value;
            end
            if (apdu_len4 != 8'd0) begin
               if (pos < 5 + int'(apdu_len4)) begin
                  data_hit = 1'b1;
               end else if (pos == 5 + int'(apdu_len4)) begin
                  apdu_le_bytes = {8'd0, value};
                  apdu_le_count = 2'd1;
               end
            end else if (pos >= 7 && apdu_ext_len != 16'd0) begin
               if (pos < 7 + int'(apdu_ext_len)) begin
                  data_hit = 1'b1;
               end else if (pos == 7 + int'(apdu_ext_len)) begin
                  apdu_le_bytes = {value, 8'd0};
                  apdu_le_count = 2'd1;
               end else if (pos == 8 + int'(apdu_ext_len) && apdu_le_count == 2'd1) begin
                  apdu_le_bytes[7:0] = value;
                  apdu_le_count = 2'd2;
               end
            end
         end
      end
      apdu_pos = 17'(next_pos);

      if (data_hit) begin
         r = '0;
         r.kind = acp_pkg::KIND_DATA;
         r.body_byte = value;
         r.byte_count = 17'(next_pos);
         r.last_result = !last;
         expected_results.push_back(r);
      end

      if (last) begin
         ext_form = (next_pos > 5) && (apdu_len4 == 8'd0);
         lc_val = 0;
         le_val = 0;
         if (!ext_form) begin
            if (next_pos > 5) begin
               lc_val = int'(apdu_len4);
               if (apdu_le_count >= 2'd1) begin
                  le_val = (apdu_le_bytes == 16'd0) ? int'(acp_pkg::SHORT_LE_MAX)
                                                    : int'(apdu_le_bytes[7:0]);
               end
            end else if (next_pos == 5) begin
               le_val = (apdu_len4 == 8'd0) ? int'(acp_pkg::SHORT_LE_MAX)
                                            : int'(apdu_len4);
            end
         end else if (next_pos <= 7 || apdu_ext_len == 16'd0) begin
            if (next_pos >= 7) begin
               le_val = (apdu_ext_len == 16'd0) ? int'(acp_pkg::EXT_LE_MAX)
                                                : int'(apdu_ext_len);
            end
         end else begin
            lc_val = int'(apdu_ext_len);
            if (apdu_le_count >= 2'd2) begin
               le_val = (apdu_le_bytes == 16'd0) ? int'(acp_pkg::EXT_LE_MAX)
                                                 : int'(apdu_le_bytes);
            end
         end
         r = '0;
         r.kind = acp_pkg::KIND_SUMMARY;
         r.cla = apdu_header[7:0];
         r.ins = apdu_header[15:8];
         r.p1 = apdu_header[23:16];
         r.p2 = apdu_header[31:24];
         r.lc = 16'(lc_val);
         r.le = 17'(le_val);
         r.extended = ext_form;
         r.secure_messaging = (apdu_header[7:0] & acp_pkg::CLA_NIBBLE_MASK) ==
                              {4'd0, sm_nibble_model};
         r.byte_count = 17'(next_pos);
         r.last_result = 1'b1;
         expected_results.push_back(r);
         apdu_pos = '0;
         apdu_header = '0;
         apdu_len4 = '0;
         apdu_ext_len = '0;
         apdu_le_bytes = '0;
         apdu_le_count = '0;
      end
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] random_le_byte();
      return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
   endfunction

   function automatic int pick_short_lc();
      return ($urandom_range(0, 39) == 0) ? $urandom_range(200, 255) : $urandom_range(1, 16);
   endfunction

   function automatic int pick_ext_lc();
      return ($urandom_range(0, 39) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 16);
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic last);
      int gap;
      gap = tx_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.in_byte <= value;
      req_bus.is_last <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_apdu_byte(value, last);
   endtask

   task automatic send_apdu;
      foreach (apdu_bytes[i]) send_byte(apdu_bytes[i], i == apdu_bytes.size() - 1);
   endtask

   task automatic wait_drained;
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sm_nibble(input logic [3:0] nibble);
      csr_write_data <= nibble;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sm_nibble_model = nibble;
   endtask

   task automatic build_random_apdu;
      int         form;
      int         count;
      int         cut;
      logic [7:0] cla;
      apdu_bytes.delete();
      cla = 8'($urandom);
      if ($urandom_range(0, 2) == 0) cla[3:0] = sm_nibble_model;
      apdu_bytes.push_back(cla);
      repeat (3) apdu_bytes.push_back(8'($urandom));
      form = $urandom_range(0, 8);
      case (form)
         0: ;
         1: apdu_bytes.push_back(random_le_byte());
         2, 3: begin
            count = pick_short_lc();
            apdu_bytes.push_back(8'(count));
            repeat (count) apdu_bytes.push_back(8'($urandom));
            if (form == 3) apdu_bytes.push_back(random_le_byte());
         end
         4: begin
            apdu_bytes.push_back(8'd0);
            apdu_bytes.push_back(random_le_byte());
            apdu_bytes.push_back(random_le_byte());
         end
         5, 6: begin
            count = pick_ext_lc();
            apdu_bytes.push_back(8'd0);
            apdu_bytes.push_back(8'(count >> 8));
            apdu_bytes.push_back(8'(count));
            repeat (count) apdu_bytes.push_back(8'($urandom));
            if (form == 6) begin
               apdu_bytes.push_back(random_le_byte());
               apdu_bytes.push_back(random_le_byte());
            end
         end
         7: begin
            // large extended Lc, data cut short
            apdu_bytes.push_back(8'd0);
            apdu_bytes.push_back(8'($urandom_range(128, 255)));
            apdu_bytes.push_back(8'($urandom));
            repeat ($urandom_range(0, 4)) apdu_bytes.push_back(8'($urandom));
         end
         default: begin
            apdu_bytes.delete();
            repeat ($urandom_range(1, 12)) apdu_bytes.push_back(8'($urandom));
         end
      endcase
      if (form < 7) begin
         case ($urandom_range(0, 7))
            0: begin
               cut = $urandom_range(1, apdu_bytes.size());
               while (apdu_bytes.size() > cut) void'(apdu_bytes.pop_back());
            end
            1: repeat ($urandom_range(1, 3)) apdu_bytes.push_back(8'($urandom));
            default: ;
         endcase
      end
   endtask

   task automatic test_directed_forms;
      tx_gaps_on = 1'b0;
      rx_stalls_on = 1'b0;
      apdu_bytes = '{8'h0C};
      send_apdu();
      apdu_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hAA, 8'h00, 8'h55};
      send_apdu();
      apdu_bytes = '{8'h00, 8'hB0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_apdu();
      apdu_bytes = '{8'h0C, 8'hDA, 8'h80, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'h5A, 8'hA5};
      send_apdu();
      wait_drained();
   endtask

   task automatic test_random_apdus(input int item_target, input logic [3:0] nibble,
                                    input bit gaps, input bit stalls);
      int sent;
      wait_drained();
      write_sm_nibble(nibble);
      tx_gaps_on = gaps;
      rx_stalls_on = stalls;
      sent = 0;
      while (sent < item_target) begin
         build_random_apdu();
         send_apdu();
         sent += apdu_bytes.size();
      end
   endtask

   task automatic test_backpressure;
      wait_drained();
      tx_gaps_on = 1'b0;
      rx_stalls_on = 1'b0;
      hold_requests++;
      repeat (3) begin
         apdu_bytes.delete();
         repeat (4) apdu_bytes.push_back(8'($urandom));
         apdu_bytes.push_back(8'd24);
         repeat (24) apdu_bytes.push_back(8'($urandom));
         apdu_bytes.push_back(random_le_byte());
         send_apdu();
      end
      wait_drained();
      tx_gaps_on = 1'b1;
      rx_stalls_on = 1'b1;
      hold_requests++;
      repeat (4) begin
         build_random_apdu();
         send_apdu();
      end
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= RSP_HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
         stall_left <= pick_gap();
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      apdu_result_type got;
      apdu_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.kind = rsp_bus.kind;
         got.body_byte = rsp_bus.body_byte;
         got.cla = rsp_bus.cla;
         got.ins = rsp_bus.ins;
         got.p1 = rsp_bus.p1;
         got.p2 = rsp_bus.p2;
         got.lc = rsp_bus.lc;
         got.le = rsp_bus.le;
         got.extended = rsp_bus.extended;
         got.secure_messaging = rsp_bus.secure_messaging;
         got.byte_count = rsp_bus.byte_count;
         got.last_result = rsp_bus.last_result;
         if (expected_results.size() == 0) begin
            flag_error("result transaction with nothing outstanding");
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               flag_error($sformatf("result got %h expected %h", got, want));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == STUCK_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.in_byte = '0;
      req_bus.is_last = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_forms();
      test_random_apdus(350, 4'd0, 1'b1, 1'b1);
      test_random_apdus(350, 4'd15, 1'b0, 1'b0);
      test_random_apdus(450, 4'($urandom), 1'b1, 1'b1);
      test_random_apdus(350, acp_pkg::SM_NIBBLE_RESET, 1'b1, 1'b0);
      test_backpressure();

      wait_drained();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
